// ===== design/ncst_pkg.sv =====
// -----------------------------------------------------------------------------
// ncst_pkg
// Shared types, widths and codes for the nearest-centroid score table unit.
// -----------------------------------------------------------------------------
package ncst_pkg;

   // default sizes of the stores
   localparam int MAX_CLUSTERS_DEF = 256;
   localparam int MAX_FEATURES_DEF = 8;
   localparam int ALPHABET_DEF     = 32;

   // fixed field widths
   localparam int KIND_W    = 2;
   localparam int FEATURE_W = 3;
   localparam int LETTER_W  = 5;
   localparam int CLUSTER_W = 8;
   localparam int SCORE_W   = 16;
   localparam int SUM_W     = 19;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_NC_W    = 9;
   localparam int CSR_NF_W    = 4;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLUSTERS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEATURES = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_SCORE    = 2'd0,
      KIND_CENTROID = 2'd1,
      KIND_COLUMN   = 2'd2,
      KIND_NONE     = 2'd3
   } item_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN
   } state_type;

   // one accepted request, broadcast to every feature lane
   typedef struct packed {
      logic                        valid;
      item_kind_type               kind;
      logic [FEATURE_W-1:0]        feature;
      logic [LETTER_W-1:0]         letter;
      logic [LETTER_W-1:0]         partner;
      logic [CLUSTER_W-1:0]        cluster;
      logic signed [SCORE_W-1:0]   score;
   } item_type;

endpackage

// ===== design/ncst_if.sv =====
// -----------------------------------------------------------------------------
// ncst_req_if / ncst_rsp_if
// Valid/ready channels for requests and classification responses.
// -----------------------------------------------------------------------------
interface ncst_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [ncst_pkg::KIND_W-1:0]          kind;
   logic [ncst_pkg::FEATURE_W-1:0]       feature;
   logic [ncst_pkg::LETTER_W-1:0]        letter;
   logic [ncst_pkg::LETTER_W-1:0]        partner_letter;
   logic [ncst_pkg::CLUSTER_W-1:0]       cluster;
   logic signed [ncst_pkg::SCORE_W-1:0]  entry_score;
   logic                                 last;

   modport source (output valid, kind, feature, letter, partner_letter, cluster,
                   entry_score, last, input ready);
   modport sink   (input valid, kind, feature, letter, partner_letter, cluster,
                   entry_score, last, output ready);
endinterface

interface ncst_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [ncst_pkg::CLUSTER_W-1:0]       best_cluster;
   logic signed [ncst_pkg::SUM_W-1:0]    best_score;

   modport source (output valid, best_cluster, best_score, input ready);
   modport sink   (input valid, best_cluster, best_score, output ready);
endinterface

// ===== design/ncst_ram.sv =====
// -----------------------------------------------------------------------------
// ncst_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module ncst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/ncst_lane.sv =====
// -----------------------------------------------------------------------------
// ncst_lane
// One feature position: column letter, centroid letter bank and score bank.
// -----------------------------------------------------------------------------
module ncst_lane #(
   parameter int FEAT         = 0,
   parameter int MAX_CLUSTERS = ncst_pkg::MAX_CLUSTERS_DEF,
   parameter int ALPHABET     = ncst_pkg::ALPHABET_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ncst_pkg::item_type                    item,
   input  logic                                  feat_en,
   input  logic [$clog2(MAX_CLUSTERS)-1:0]       rd_cluster,
   output logic signed [ncst_pkg::SCORE_W-1:0]   pair_score
);
   import ncst_pkg::*;

   localparam int CIW    = $clog2(MAX_CLUSTERS);
   localparam int AIW    = $clog2(ALPHABET);
   localparam int TIW    = 2 * AIW;
   localparam int TDEPTH = 1 << TIW;

   logic [LETTER_W-1:0] column_ff, column_in;
   logic                feat_hit;
   logic                cent_we, score_we;
   logic [LETTER_W-1:0] cent_letter;
   logic [TIW-1:0]      score_wr_addr, score_rd_addr;
   logic [SCORE_W-1:0]  score_data;
   logic                use_ff, use_in;

   function automatic logic letter_ok(input logic [LETTER_W-1:0] l);
      return int'(l) < ALPHABET;
   endfunction

   assign feat_hit = item.valid && (int'(item.feature) == FEAT);
   assign cent_we  = feat_hit && (item.kind == KIND_CENTROID)
                     && (int'(item.cluster) < MAX_CLUSTERS);
   assign score_we = feat_hit && (item.kind == KIND_SCORE)
                     && letter_ok(item.letter) && letter_ok(item.partner);
   assign score_wr_addr = {AIW'(item.letter), AIW'(item.partner)};

   always_comb begin
      column_in = column_ff;
      if (feat_hit && (item.kind == KIND_COLUMN)) begin
         column_in = item.letter;
      end
   end

   ncst_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_CLUSTERS)) u_centroid_ram (
      .clock   (clock),
      .wr_en   (cent_we),
      .wr_addr (CIW'(item.cluster)),
      .wr_data (item.letter),
      .rd_addr (rd_cluster),
      .rd_data (cent_letter)
   );

   // second stage: look up the pair score of column and centroid letters
   assign score_rd_addr = {AIW'(column_ff), AIW'(cent_letter)};
   assign use_in = feat_en && letter_ok(column_ff) && letter_ok(cent_letter);

   ncst_ram #(.WIDTH(SCORE_W), .DEPTH(TDEPTH)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_wr_addr),
      .wr_data (item.score),
      .rd_addr (score_rd_addr),
      .rd_data (score_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
      end else begin
         column_ff <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      use_ff <= use_in;
   end

   // drop features out of use and letters beyond the alphabet
   assign pair_score = use_ff ? signed'(score_data) : '0;
endmodule

// ===== design/nearest_centroid_by_score_table_unit.sv =====
// -----------------------------------------------------------------------------
// nearest_centroid_by_score_table_unit
// Nearest-centroid classifier over per-feature letter-pair score tables.
// -----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per item: a score table entry load, a
//   centroid letter load, or one column letter. Loads and column letters
//   without the last mark give no response; while idle, each is taken at once.
//   A column letter with last set starts a sweep over the clusters in use:
//   one centroid is issued per cycle into a five-stage pipeline (centroid
//   bank read, score bank read, group add, total add with saturation, best
//   compare). The response enters rsp_ch once the last cluster has passed
//   the best compare; the sweep length is set by the single read port
//   of each centroid bank, one cluster per cycle.
//   req_ch.ready is low from that transaction until the response enters the
//   output register and high otherwise, so loads are taken while a finished
//   response waits.
//   If rsp_ch stalls, a following sweep holds at its end, with req_ch.ready
//   low, until the output register is free.
//   csr_we writes clusters_in_use or features_in_use; write only while idle.
//   Reset clears both registers to 1, the column letters to zero and the
//   handshake state; the score and centroid banks are not cleared.
// -----------------------------------------------------------------------------
module nearest_centroid_by_score_table_unit #(
   parameter int MAX_CLUSTERS = ncst_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_FEATURES = ncst_pkg::MAX_FEATURES_DEF,
   parameter int ALPHABET     = ncst_pkg::ALPHABET_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ncst_req_if.sink                             req_ch,
   ncst_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [ncst_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ncst_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ncst_pkg::*;

   localparam int CIW   = $clog2(MAX_CLUSTERS);
   localparam int NGRP  = (MAX_FEATURES + 3) / 4;
   localparam int GRP_W = SCORE_W + 2;
   localparam int TOT_W = SCORE_W + 4;
   localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'((1 << (SUM_W - 1)) - 1);
   localparam logic signed [TOT_W-1:0] SAT_LO = -SAT_HI - TOT_W'(1);

   // configuration registers
   logic [CSR_NC_W-1:0] clusters_ff, clusters_in;
   logic [CSR_NF_W-1:0] features_ff, features_in;
   logic [CSR_NC_W-1:0] nc_clamped;
   logic [CIW-1:0]      last_idx;

   // control
   state_type      state_ff, state_in;
   logic           req_fire, start;
   logic           issuing, pipe_busy, out_load;
   logic [CIW-1:0] issue_ff, issue_in;
   item_type       item;

   // pipeline valid and cluster index per stage
   logic           v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CIW-1:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;

   // arithmetic
   logic signed [SCORE_W-1:0] lane_score [MAX_FEATURES];
   logic [MAX_FEATURES-1:0]   feat_en;
   logic signed [GRP_W-1:0]   grp_ff [NGRP];
   logic signed [GRP_W-1:0]   grp_in [NGRP];
   logic signed [TOT_W-1:0]   total;
   logic signed [SUM_W-1:0]   sat_ff, sat_in;
   logic [CIW-1:0]            best_idx_ff;
   logic signed [SUM_W-1:0]   best_score_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_W-1:0]      rsp_cluster_ff;
   logic signed [SUM_W-1:0]   rsp_score_ff;

   // ---------------------------------------------------------------- config
   always_comb begin
      clusters_in = clusters_ff;
      features_in = features_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CLUSTERS: clusters_in = csr_wdata[CSR_NC_W-1:0];
            CSR_FEATURES: features_in = csr_wdata[CSR_NF_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the cluster count to 1..MAX_CLUSTERS
   always_comb begin
      nc_clamped = clusters_ff;
      if (clusters_ff == '0) begin
         nc_clamped = CSR_NC_W'(1);
      end else if (int'(clusters_ff) > MAX_CLUSTERS) begin
         nc_clamped = CSR_NC_W'(MAX_CLUSTERS);
      end
   end
   assign last_idx = CIW'(nc_clamped - CSR_NC_W'(1));

   // feature 0 is always in use; the rest follow features_in_use
   always_comb begin
      for (int f = 0; f < MAX_FEATURES; f++) begin
         feat_en[f] = (f == 0) || (f < int'(features_ff));
      end
   end

   // ---------------------------------------------------------------- intake
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      item.valid   = req_fire;
      item.kind    = item_kind_type'(req_ch.kind);
      item.feature = req_ch.feature;
      item.letter  = req_ch.letter;
      item.partner = req_ch.partner_letter;
      item.cluster = req_ch.cluster;
      item.score   = req_ch.entry_score;
   end

   assign start = req_fire && (item.kind == KIND_COLUMN) && req_ch.last;

   // ---------------------------------------------------------------- lanes
   for (genvar f = 0; f < MAX_FEATURES; f++) begin : g_lane
      ncst_lane #(
         .FEAT         (f),
         .MAX_CLUSTERS (MAX_CLUSTERS),
         .ALPHABET     (ALPHABET)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .item       (item),
         .feat_en    (feat_en[f]),
         .rd_cluster (issue_ff),
         .pair_score (lane_score[f])
      );
   end

   // ---------------------------------------------------------------- sequencer
   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (issue_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy && (!rsp_valid_ff || rsp_ch.ready)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      issuing      = 1'b0;
      out_load     = 1'b0;
      issue_in     = issue_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            issue_in     = '0;
         end
         ST_SWEEP: begin
            issuing  = 1'b1;
            issue_in = issue_ff + CIW'(1);
         end
         ST_DRAIN: begin
            out_load = !pipe_busy && (!rsp_valid_ff || rsp_ch.ready);
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- adders
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < 4; k++) begin
            if (g * 4 + k < MAX_FEATURES) begin
               grp_in[g] = grp_in[g] + GRP_W'(lane_score[g * 4 + k]);
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < NGRP; g++) begin
         total = total + TOT_W'(grp_ff[g]);
      end
      if (total > SAT_HI) begin
         sat_in = SUM_W'(SAT_HI);
      end else if (total < SAT_LO) begin
         sat_in = SUM_W'(SAT_LO);
      end else begin
         sat_in = SUM_W'(total);
      end
   end

   // ---------------------------------------------------------------- response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.best_cluster = rsp_cluster_ff;
   assign rsp_ch.best_score   = rsp_score_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clusters_ff  <= CSR_NC_W'(1);
         features_ff  <= CSR_NF_W'(1);
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clusters_ff  <= clusters_in;
         features_ff  <= features_in;
         state_ff     <= state_in;
         v1_ff        <= issuing;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      idx1_ff  <= issue_ff;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      idx4_ff  <= idx3_ff;
      grp_ff   <= grp_in;
      sat_ff   <= sat_in;
      // take cluster 0 first, then only a strictly greater sum
      if (v4_ff && ((idx4_ff == '0) || (sat_ff > best_score_ff))) begin
         best_idx_ff   <= idx4_ff;
         best_score_ff <= sat_ff;
      end
      if (out_load) begin
         rsp_cluster_ff <= CLUSTER_W'(best_idx_ff);
         rsp_score_ff   <= best_score_ff;
      end
   end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-centroid score table unit. A scoreboard
// class mirrors the score tables, centroid letters, column letters and both
// registers, predicts the winning cluster and its summed score for every
// column closed by a last mark, and compares each response field by field.
// -----------------------------------------------------------------------------
module tb;
   import ncst_pkg::*;

   localparam int SETTLE_CYCLES     = 10;
   localparam int SWEEP_TAIL_CYCLES = 300;
   localparam int ITEM_TARGET       = 2000;
   localparam int HOLD_PHASE        = 6;
   localparam int HOLD_CYCLES       = 600;
   localparam int SUM_MAX           = 262143;
   localparam int SUM_MIN           = -262144;

   typedef struct packed {
      item_kind_type               kind;
      logic [FEATURE_W-1:0]        feature;
      logic [LETTER_W-1:0]         letter;
      logic [LETTER_W-1:0]         partner;
      logic [CLUSTER_W-1:0]        cluster;
      logic signed [SCORE_W-1:0]   score;
      logic                        last;
   } request_type;

   typedef struct packed {
      logic [CLUSTER_W-1:0]        cluster;
      logic signed [SUM_W-1:0]     score;
   } verdict_type;

   // Mirror of the block: stores, registers and the verdicts still owed.
   class classification_tracker;
      logic signed [SCORE_W-1:0] pair_score [MAX_FEATURES_DEF][ALPHABET_DEF][ALPHABET_DEF];
      bit                        score_written [MAX_FEATURES_DEF][ALPHABET_DEF][ALPHABET_DEF];
      logic [LETTER_W-1:0]       centroid_letter [MAX_CLUSTERS_DEF][MAX_FEATURES_DEF];
      bit                        centroid_written [MAX_CLUSTERS_DEF][MAX_FEATURES_DEF];
      logic [LETTER_W-1:0]       column_letter [MAX_FEATURES_DEF];
      logic [CSR_NC_W-1:0]       clusters_reg;
      logic [CSR_NF_W-1:0]       features_reg;
      verdict_type               pending_verdicts [$];
      int                        mismatch_count;

      function new();
         foreach (pair_score[f, a, b]) begin
            pair_score[f][a][b]    = '0;
            score_written[f][a][b] = 1'b0;
         end
         foreach (centroid_letter[c, f]) begin
            centroid_letter[c][f]  = '0;
            centroid_written[c][f] = 1'b0;
         end
         foreach (column_letter[f]) column_letter[f] = '0;
         clusters_reg   = 1;
         features_reg   = 1;
         mismatch_count = 0;
      endfunction

      function int active_clusters();
         if (clusters_reg == 0) return 1;
         if (clusters_reg > MAX_CLUSTERS_DEF) return MAX_CLUSTERS_DEF;
         return clusters_reg;
      endfunction

      function int active_features();
         if (features_reg == 0) return 1;
         if (features_reg > MAX_FEATURES_DEF) return MAX_FEATURES_DEF;
         return features_reg;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] reg_index,
                                   logic [CSR_DATA_W-1:0] data);
         if (reg_index == CSR_CLUSTERS) clusters_reg = data[CSR_NC_W-1:0];
         else features_reg = data[CSR_NF_W-1:0];
      endfunction

      // Sweep all clusters in use; a later cluster wins only on a strictly greater sum.
      function verdict_type classify_column();
         verdict_type best;
         int          sum;
         int          best_sum;
         best_sum = 0;
         best     = '0;
         for (int c = 0; c < active_clusters(); c++) begin
            sum = 0;
            for (int f = 0; f < active_features(); f++)
               sum += pair_score[f][column_letter[f]][centroid_letter[c][f]];
            if (sum > SUM_MAX) sum = SUM_MAX;
            if (sum < SUM_MIN) sum = SUM_MIN;
            if (c == 0 || sum > best_sum) begin
               best_sum     = sum;
               best.cluster = c[CLUSTER_W-1:0];
            end
         end
         best.score = best_sum[SUM_W-1:0];
         return best;
      endfunction

      function void absorb_request(request_type r);
         case (r.kind)
            KIND_SCORE: begin
               pair_score[r.feature][r.letter][r.partner]    = r.score;
               score_written[r.feature][r.letter][r.partner] = 1'b1;
            end
            KIND_CENTROID: begin
               centroid_letter[r.cluster][r.feature]  = r.letter;
               centroid_written[r.cluster][r.feature] = 1'b1;
            end
            KIND_COLUMN: begin
               column_letter[r.feature] = r.letter;
               if (r.last) pending_verdicts = {pending_verdicts, classify_column()};
            end
            default: ;
         endcase
      endfunction

      function void check_verdict(logic [CLUSTER_W-1:0] got_cluster,
                                  logic signed [SUM_W-1:0] got_score);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected response, expected none, got cluster %0d score %0d",
                     $time, got_cluster, got_score);
            mismatch_count++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got_cluster !== want.cluster) begin
            $display("%0t: best_cluster expected %0d, got %0d",
                     $time, want.cluster, got_cluster);
            mismatch_count++;
         end
         if (got_score !== want.score) begin
            $display("%0t: best_score expected %0d, got %0d",
                     $time, $signed(want.score), got_score);
            mismatch_count++;
         end
      endfunction

      function int waiting();
         return pending_verdicts.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   ncst_req_if req_ch ();
   ncst_rsp_if rsp_ch ();

   classification_tracker tracker = new();

   int requests_sent = 0;   // accepted transactions that the block acts on
   bit gapless       = 0;   // phase with no idling on either side
   int hold_request  = 0;   // cycles the response side must hold off next

   // register corners at the start of the random part; 256 clusters stay at
   // one or two features so the centroid loads stay cheap
   int nc_corner [6] = '{0, 511, 257, 256, 1, 2};
   int nf_corner [6] = '{15, 1, 0, 2, 9, 8};

   nearest_centroid_by_score_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Hard stop in case the block hangs.
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gapless || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Favor a few letters so table entries and ties get reused.
   function automatic logic [LETTER_W-1:0] pick_letter();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return LETTER_W'($urandom_range(0, 3));
      if (r < 9) return LETTER_W'($urandom);
      return '1;
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      if (r < 5) return SCORE_W'($urandom);
      v = $signed($urandom_range(0, 1024)) - 512;
      return v[SCORE_W-1:0];
   endfunction

   // Response side: random stalls, plus a long hold-off when asked for.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Compare every accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_verdict(rsp_ch.best_cluster, rsp_ch.best_score);
   end

   // Offer one transaction after a random gap and hold it until it is taken.
   task automatic send_item(input item_kind_type kind,
                            input logic [FEATURE_W-1:0] feature,
                            input logic [LETTER_W-1:0] letter,
                            input logic [LETTER_W-1:0] partner,
                            input logic [CLUSTER_W-1:0] cluster,
                            input logic signed [SCORE_W-1:0] score,
                            input logic last);
      request_type r;
      int          gap;
      r   = '{kind, feature, letter, partner, cluster, score, last};
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.kind           <= kind;
      req_ch.feature        <= feature;
      req_ch.letter         <= letter;
      req_ch.partner_letter <= partner;
      req_ch.cluster        <= cluster;
      req_ch.entry_score    <= score;
      req_ch.last           <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.absorb_request(r);
      if (kind != KIND_NONE) requests_sent++;
   endtask

   // Drop valid, then wait until every prediction has been answered.
   task automatic drain_results(input int settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.waiting() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] reg_index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      tracker.write_register(reg_index, data);
   endtask

   // Load whatever the coming sweep would read but was never written, so the
   // block never reads an undefined table entry or centroid letter.
   task automatic fill_missing_entries(input logic [FEATURE_W-1:0] final_feature,
                                       input logic [LETTER_W-1:0] final_letter);
      logic [LETTER_W-1:0] column [MAX_FEATURES_DEF];
      logic [LETTER_W-1:0] partner;
      column                = tracker.column_letter;
      column[final_feature] = final_letter;
      for (int c = 0; c < tracker.active_clusters(); c++) begin
         for (int f = 0; f < tracker.active_features(); f++) begin
            if (!tracker.centroid_written[c][f])
               send_item(KIND_CENTROID, FEATURE_W'(f), pick_letter(), LETTER_W'($urandom),
                         CLUSTER_W'(c), SCORE_W'($urandom), 1'($urandom));
            partner = tracker.centroid_letter[c][f];
            if (!tracker.score_written[f][column[f]][partner])
               send_item(KIND_SCORE, FEATURE_W'(f), column[f], partner,
                         CLUSTER_W'($urandom), pick_score(), 1'($urandom));
         end
      end
   endtask

   // One column: usually features in order up to the count in use, sometimes
   // random features (some beyond the count), sometimes a lone last letter.
   task automatic send_column();
      int                   mode;
      int                   count;
      logic [FEATURE_W-1:0] f;
      logic [LETTER_W-1:0]  a;
      mode  = $urandom_range(0, 9);
      count = (mode < 7) ? tracker.active_features() :
              (mode < 9) ? $urandom_range(1, MAX_FEATURES_DEF) : 1;
      for (int i = 0; i < count - 1; i++) begin
         f = (mode < 7) ? FEATURE_W'(i) : FEATURE_W'($urandom);
         send_item(KIND_COLUMN, f, pick_letter(), LETTER_W'($urandom), CLUSTER_W'($urandom),
                   SCORE_W'($urandom), 1'b0);
      end
      f = (mode < 7) ? FEATURE_W'(count - 1) : FEATURE_W'($urandom);
      a = pick_letter();
      fill_missing_entries(f, a);
      send_item(KIND_COLUMN, f, a, LETTER_W'($urandom), CLUSTER_W'($urandom),
                SCORE_W'($urandom), 1'b1);
   endtask

   // Stray loads anywhere in the stores and items of the unused kind.
   task automatic send_noise();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0)
         send_item(KIND_SCORE, FEATURE_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                   CLUSTER_W'($urandom), pick_score(), 1'($urandom));
      else if (r == 1)
         send_item(KIND_CENTROID, FEATURE_W'($urandom), LETTER_W'($urandom),
                   LETTER_W'($urandom), CLUSTER_W'($urandom), SCORE_W'($urandom),
                   1'($urandom));
      else
         send_item(KIND_NONE, FEATURE_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                   CLUSTER_W'($urandom), SCORE_W'($urandom), 1'($urandom));
   endtask

   initial begin
      int                  columns;
      int                  r;
      logic [CSR_NC_W-1:0] nc_raw;
      logic [CSR_NF_W-1:0] nf_raw;

      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.kind           = KIND_NONE;
      req_ch.feature        = '0;
      req_ch.letter         = '0;
      req_ch.partner_letter = '0;
      req_ch.cluster        = '0;
      req_ch.entry_score    = '0;
      req_ch.last           = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: one cluster, one feature. The last mark on a load
      // and any item of the unused kind must give nothing.
      send_item(KIND_CENTROID, 0, 0, LETTER_W'($urandom), 0, SCORE_W'($urandom), 1'b0);
      send_item(KIND_SCORE, 0, 0, 0, CLUSTER_W'($urandom), 16'sh7fff, 1'b1);
      send_item(KIND_NONE, FEATURE_W'($urandom), LETTER_W'($urandom), LETTER_W'($urandom),
                CLUSTER_W'($urandom), SCORE_W'($urandom), 1'b1);
      send_item(KIND_COLUMN, 0, 0, LETTER_W'($urandom), CLUSTER_W'($urandom),
                SCORE_W'($urandom), 1'b1);

      // Eight features, each at the most negative entry: the sum reaches the
      // bottom of the result range. Features 1..7 of the column still hold
      // their reset letter.
      drain_results(SETTLE_CYCLES);
      write_csr(CSR_FEATURES, CSR_DATA_W'(MAX_FEATURES_DEF));
      for (int f = 1; f < MAX_FEATURES_DEF; f++)
         send_item(KIND_CENTROID, FEATURE_W'(f), 0, LETTER_W'($urandom), 0,
                   SCORE_W'($urandom), 1'b0);
      for (int f = 0; f < MAX_FEATURES_DEF; f++)
         send_item(KIND_SCORE, FEATURE_W'(f), 0, 0, CLUSTER_W'($urandom), 16'sh8000, 1'b0);
      send_item(KIND_COLUMN, 3'd7, 0, LETTER_W'($urandom), CLUSTER_W'($urandom),
                SCORE_W'($urandom), 1'b1);

      // Three clusters: a later cluster strictly ahead wins, then a three-way
      // tie goes to the lowest index.
      drain_results(SETTLE_CYCLES);
      write_csr(CSR_CLUSTERS, 9'd3);
      write_csr(CSR_FEATURES, 9'd1);
      send_item(KIND_CENTROID, 0, 0, LETTER_W'($urandom), 1, SCORE_W'($urandom), 1'b0);
      send_item(KIND_CENTROID, 0, 5, LETTER_W'($urandom), 2, SCORE_W'($urandom), 1'b0);
      send_item(KIND_SCORE, 0, 0, 5, CLUSTER_W'($urandom), -16'sd5, 1'b0);
      send_item(KIND_COLUMN, 0, 0, LETTER_W'($urandom), CLUSTER_W'($urandom),
                SCORE_W'($urandom), 1'b1);
      send_item(KIND_SCORE, 0, 0, 5, CLUSTER_W'($urandom), 16'sh8000, 1'b0);
      send_item(KIND_COLUMN, 0, 0, LETTER_W'($urandom), CLUSTER_W'($urandom),
                SCORE_W'($urandom), 1'b1);

      // Random phases: reconfigure while idle, then columns with stray items.
      for (int phase = 0; requests_sent < ITEM_TARGET || phase <= HOLD_PHASE; phase++) begin
         drain_results(SETTLE_CYCLES);
         if (phase < 6) begin
            nc_raw = CSR_NC_W'(nc_corner[phase]);
            nf_raw = CSR_NF_W'(nf_corner[phase]);
         end else if (phase == HOLD_PHASE) begin
            nc_raw = CSR_NC_W'(3);
            nf_raw = CSR_NF_W'(4);
         end else begin
            r = $urandom_range(0, 19);
            if (r < 8) nc_raw = CSR_NC_W'($urandom_range(1, 4));
            else if (r < 13) nc_raw = CSR_NC_W'($urandom_range(5, 16));
            else if (r < 15) nc_raw = CSR_NC_W'($urandom_range(17, 64));
            else if (r < 16) nc_raw = CSR_NC_W'($urandom_range(65, 255));
            else if (r < 17) nc_raw = CSR_NC_W'(256);
            else if (r < 18) nc_raw = CSR_NC_W'(0);
            else if (r < 19) nc_raw = CSR_NC_W'($urandom_range(257, 511));
            else nc_raw = CSR_NC_W'(1);
            r = $urandom_range(0, 9);
            if (r < 3) nf_raw = CSR_NF_W'($urandom_range(1, 2));
            else if (r < 7) nf_raw = CSR_NF_W'($urandom_range(3, 8));
            else if (r < 8) nf_raw = CSR_NF_W'(8);
            else if (r < 9) nf_raw = CSR_NF_W'(0);
            else nf_raw = CSR_NF_W'($urandom_range(9, 15));
         end
         write_csr(CSR_CLUSTERS, nc_raw);
         // keep wide sweeps narrow in features to bound the centroid loads
         if (tracker.active_clusters() > 64 && nf_raw > 2)
            nf_raw = CSR_NF_W'($urandom_range(0, 2));
         write_csr(CSR_FEATURES, {5'($urandom), nf_raw});

         gapless = (phase == HOLD_PHASE) || ($urandom_range(0, 4) == 0);
         // hold the response side off so the block backs up and drops ready
         if (phase == HOLD_PHASE) hold_request = HOLD_CYCLES;
         columns = (phase == HOLD_PHASE) ? 8 : $urandom_range(2, 8);
         repeat (columns) begin
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_noise();
            send_column();
         end
      end

      drain_results(SWEEP_TAIL_CYCLES);
      if (tracker.mismatch_count == 0 && tracker.waiting() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
